[rtl/core/cpfs_pkg.sv]
// shared types, codes, constants and the arctangent table for the pupil field sum block
package cpfs_pkg;

    // defaults for the top-level parameters
    localparam int MAX_SAMPLES_DEF     = 256;
    localparam int CORDIC_STEPS_DEF    = 24;
    localparam int INTENSITY_SHIFT_DEF = 32;

    // command codes carried in tuser
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_EVAL  = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_EMPTY  = 3'd1;
    localparam logic [2:0] ST_ORIGIN = 3'd2;
    localparam logic [2:0] ST_ZPOW   = 3'd3;
    localparam logic [2:0] ST_FULL   = 3'd4;
    localparam logic [2:0] ST_SAT    = 3'd5;

    // configuration register indexes
    localparam logic CFG_WAVELENGTH = 1'b0;
    localparam logic CFG_REF_PATH   = 1'b1;

    localparam logic [23:0] WL_RESET     = 24'd604731;
    localparam logic [63:0] PI_Q36       = 64'h0000_0032_43F6_A888;
    localparam logic [63:0] QPI_Q62      = 64'h3243_F6A8_885A_308D;
    localparam logic [63:0] INV_GAIN_Q32 = 64'h0000_0000_9B74_EDA8;
    localparam logic [47:0] AMP_MAX      = 48'hFFFF_FFFF_FFFF;

    // cordic datapath widths
    localparam int COR_XW = 56;
    localparam int COR_ZW = 44;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_su_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_su_stat;

    typedef struct packed {
        logic [31:0] power;
        logic [47:0] path;
        logic [47:0] oz;
        logic [47:0] oy;
        logic [47:0] ox;
    } t_sample;

    typedef enum logic [5:0] {
        S_IDLE, S_PWR_RD, S_PWR_CHK, S_ORG_RD, S_ORG_CHK, S_SMP_RD,
        S_SQX_GO, S_SQX_WT, S_SQY_GO, S_SQY_WT, S_SQZ_GO, S_SQZ_WT,
        S_DST_GO, S_DST_WT, S_PWS_GO, S_PWS_WT, S_AMP_GO, S_AMP_WT,
        S_X0_GO, S_X0_WT, S_PH_GO, S_PH_WT, S_FOLD, S_ANM_GO, S_ANM_WT,
        S_AND_GO, S_AND_WT, S_ROT_GO, S_ROT_WT, S_FX_GO, S_FX_WT,
        S_FY_GO, S_FY_WT, S_FIN, S_OUT
    } t_state;

    typedef logic [63:0][39:0] t_atan_tab;

    // 2^e / d by long division, elaboration only
    function automatic logic [63:0] pow2_div(int e, int d);
        logic [63:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], (b == e)};
            if (rem >= 64'(d)) begin
                rem  = rem - 64'(d);
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in Q36, rounded from a truncated Q62 series
    function automatic t_atan_tab build_atan();
        t_atan_tab   tab;
        logic [63:0] v;
        logic [63:0] term;
        int          k;
        for (int i = 0; i < 64; i++) begin
            v = '0;
            if (i == 0) begin
                v = QPI_Q62;
            end else if (i < 62) begin
                k = 0;
                while (i * (2 * k + 1) <= 62) begin
                    term = pow2_div(62 - i * (2 * k + 1), 2 * k + 1);
                    if (k % 2 == 1) v = v - term;
                    else            v = v + term;
                    k++;
                end
            end
            term   = (v + (64'd1 << 25)) >> 26;
            tab[i] = term[39:0];
        end
        return tab;
    endfunction

    localparam t_atan_tab ATAN_TAB = build_atan();

endpackage

[rtl/core/cpfs_mem.sv]
// sample table: origin, exit path and power per entry, one write and one registered read port
module cpfs_mem import cpfs_pkg::*; #(
    parameter int DEPTH  = MAX_SAMPLES_DEF,
    parameter int ADDR_W = 8
) (
    input  logic              i_clk,
    input  logic              i_wen,
    input  logic [ADDR_W-1:0] i_waddr,
    input  t_sample           i_wdata,
    input  logic              i_ren,
    input  logic [ADDR_W-1:0] i_raddr,
    output t_sample           o_rdata
);

    t_sample r_mem [DEPTH];
    t_sample r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wen) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ren) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/cpfs_serial.sv]
// shared bit-serial unit: multiply-accumulate, restoring divide and integer square root
module cpfs_serial import cpfs_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_su_req        i_req,
    input  logic [127:0]   i_a,
    input  logic [63:0]    i_b,
    input  logic [127:0]   i_c,
    output t_su_stat       o_stat,
    output logic [127:0]   o_res,
    output logic [63:0]    o_rem
);

    logic         r_busy;
    logic         r_done;
    logic [6:0]   r_cnt;
    t_op          r_op;
    logic [127:0] r_a;
    logic [63:0]  r_b;
    logic [127:0] r_acc;
    logic [66:0]  r_rem;

    logic [127:0] n_a;
    logic [63:0]  n_b;
    logic [127:0] n_acc;
    logic [66:0]  n_rem;
    logic [66:0]  w_rsh;
    logic [66:0]  w_trial;
    logic         w_ge;
    logic [6:0]   w_last;

    always_comb begin
        n_a     = r_a;
        n_b     = r_b;
        n_acc   = r_acc;
        n_rem   = r_rem;
        w_rsh   = '0;
        w_trial = '0;
        w_ge    = 1'b0;
        w_last  = 7'd63;
        unique case (r_op)
            OP_MUL: begin
                n_acc = r_b[0] ? r_acc + r_a : r_acc;
                n_a   = r_a << 1;
                n_b   = r_b >> 1;
            end
            OP_DIV: begin
                w_last  = 7'd127;
                w_rsh   = {r_rem[65:0], r_a[127]};
                w_trial = {3'b000, r_b};
                w_ge    = w_rsh >= w_trial;
                n_rem   = w_ge ? w_rsh - w_trial : w_rsh;
                n_acc   = {r_acc[126:0], w_ge};
                n_a     = r_a << 1;
            end
            OP_SQRT: begin
                w_rsh   = {r_rem[64:0], r_a[127:126]};
                w_trial = {1'b0, r_acc[63:0], 2'b01};
                w_ge    = w_rsh >= w_trial;
                n_rem   = w_ge ? w_rsh - w_trial : w_rsh;
                n_acc   = {r_acc[126:0], w_ge};
                n_a     = r_a << 2;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= OP_MUL;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_op   <= i_req.op;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= (i_req.op == OP_MUL) ? i_c : '0;
            r_rem <= '0;
        end else if (r_busy) begin
            r_a   <= n_a;
            r_b   <= n_b;
            r_acc <= n_acc;
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_res       = r_acc;
    assign o_rem       = r_rem[63:0];

endmodule

[rtl/core/cpfs_cordic.sv]
// iterative cordic rotator, one micro-rotation per cycle
module cpfs_cordic import cpfs_pkg::*; #(
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [COR_ZW-1:0] i_z,
    input  logic signed [COR_XW-1:0] i_x0,
    output logic                     o_done,
    output logic signed [COR_XW-1:0] o_x,
    output logic signed [COR_XW-1:0] o_y
);

    localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic                     r_busy;
    logic                     r_done;
    logic [IW-1:0]            r_i;
    logic signed [COR_XW-1:0] r_x;
    logic signed [COR_XW-1:0] r_y;
    logic signed [COR_ZW-1:0] r_z;

    logic signed [COR_XW-1:0] w_xs;
    logic signed [COR_XW-1:0] w_ys;
    logic signed [COR_ZW-1:0] w_t;

    assign w_xs = r_x >>> r_i;
    assign w_ys = r_y >>> r_i;
    assign w_t  = $signed({{(COR_ZW-40){1'b0}}, ATAN_TAB[6'(r_i)]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + IW'(1);
                if (r_i == IW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_x0;
            r_y <= '0;
            r_z <= i_z;
        end else if (r_busy) begin
            if (r_z >= 0) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_t;
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_t;
            end
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;

endmodule

[rtl/core/coherent_pupil_field_sum_top.sv]
// top level of the coherent pupil field sum: sequencer, sample table and shared arithmetic
// One transfer on the slave side carries a command in tuser: clear (empties the table and the
// running total), load (stores one ray sample) or evaluate (sums the phasors of all stored
// samples at one sensor point); every command gives exactly one result transfer with the
// intensity, the running total and a status. Clear, load and unused commands go straight to
// the output state. Evaluate first reads the table twice, a read and a check per entry,
// for zero powers and for a point on a ray origin, then walks every stored sample through one
// shared bit-serial unit that multiplies one bit, divides one bit or extracts one root bit per
// cycle: three squares, two roots, three divisions and two products per sample (one product
// and two divisions are skipped at a zero wavelength), then a rotator run; the final magnitude
// adds two squares. The input is not ready while an item is being worked on; a finished result
// waits in the output register and the next item is taken meanwhile once the block is idle.
module coherent_pupil_field_sum_top import cpfs_pkg::*; #(
    parameter int MAX_SAMPLES     = MAX_SAMPLES_DEF,
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
    parameter int INTENSITY_SHIFT = INTENSITY_SHIFT_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wen,
    input  logic         i_cfg_addr,
    input  logic [47:0]  i_cfg_wdata,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [223:0] i_s_tdata,  // pos_x, pos_y, pos_z, exit_path, power
    input  logic [1:0]   i_s_tuser,  // cmd
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [127:0] o_m_tdata,  // intensity, intensity_total
    output logic [2:0]   o_m_tuser   // status
);

    localparam int ADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);

    t_state r_state, n_state;

    logic [23:0]      r_wl;
    logic [47:0]      r_ref;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [63:0]      r_total, n_total;
    logic             r_m_valid, n_m_valid;

    logic [47:0]        r_px, r_py, r_pz;
    logic [49:0]        r_dist;
    logic [50:0]        r_pd;
    logic [31:0]        r_s;
    logic [47:0]        r_amp;
    logic [47:0]        r_x0;
    logic               r_q0;
    logic [23:0]        r_m;
    logic [23:0]        r_mag;
    logic               r_neg;
    logic               r_flip;
    logic signed [COR_ZW-1:0] r_z;
    logic signed [63:0] r_fx, r_fy;
    logic               r_sat;
    logic [63:0]        r_inten;
    logic [2:0]         r_status;
    logic [63:0]        r_m_inten, r_m_total;
    logic [2:0]         r_m_status;

    t_su_req      su_req;
    t_su_stat     su_stat;
    logic [127:0] su_a, su_c, su_res;
    logic [63:0]  su_b, su_rem;

    logic    mem_wen, mem_ren;
    t_sample mem_wdata, mem_rd;

    logic                     cor_start, cor_done;
    logic signed [COR_XW-1:0] cor_x0, cor_x, cor_y;

    logic             s_acc;
    logic             w_full;
    logic             w_last;
    logic [CNT_W-1:0] w_idx_inc;
    logic             w_pwr_zero;
    logic             w_org_hit;
    logic [48:0]      w_ux, w_uy, w_uz;
    logic [50:0]      w_pd_abs;
    logic             w_amp_ovf;
    logic [63:0]      w_fx_abs, w_fy_abs;
    logic signed [COR_ZW-1:0] w_angz;
    logic signed [63:0] w_cx, w_cy;

    // phase folding
    logic               w_adj;
    logic [23:0]        w_m2;
    logic               w_odd;
    logic [24:0]        w_two_m;
    logic signed [25:0] w_r;
    logic signed [27:0] w_n4, w_n, w_wl28, w_two_wl;
    logic               w_fold;
    logic [27:0]        w_nabs;

    // final magnitude
    logic [127:0] w_shift;
    logic         w_int_ovf;
    logic [63:0]  w_int;
    logic [64:0]  w_tsum;
    logic         w_tot_ovf;

    function automatic logic [48:0] abs_diff(logic [47:0] a, logic [47:0] b);
        logic [48:0] d;
        d = {a[47], a} - {b[47], b};
        return d[48] ? ~d + 49'd1 : d;
    endfunction

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid & o_s_tready;
    assign w_full     = (r_count == CNT_W'(MAX_SAMPLES));
    assign w_idx_inc  = r_idx + CNT_W'(1);
    assign w_last     = (w_idx_inc == r_count);
    assign w_pwr_zero = (mem_rd.power == 32'd0);
    assign w_org_hit  = (r_px == mem_rd.ox) && (r_py == mem_rd.oy) && (r_pz == mem_rd.oz);

    assign w_ux     = abs_diff(r_px, mem_rd.ox);
    assign w_uy     = abs_diff(r_py, mem_rd.oy);
    assign w_uz     = abs_diff(r_pz, mem_rd.oz);
    assign w_pd_abs = r_pd[50] ? ~r_pd + 51'd1 : r_pd;
    assign w_amp_ovf = |su_res[127:48];
    assign w_fx_abs = r_fx[63] ? 64'(-r_fx) : 64'(r_fx);
    assign w_fy_abs = r_fy[63] ? 64'(-r_fy) : 64'(r_fy);
    assign w_angz   = $signed({{(COR_ZW-38){1'b0}}, su_res[37:0]});
    assign w_cx     = {{(64-COR_XW){cor_x[COR_XW-1]}}, cor_x};
    assign w_cy     = {{(64-COR_XW){cor_y[COR_XW-1]}}, cor_y};
    assign cor_x0   = $signed({{(COR_XW-48){1'b0}}, r_x0});

    // nearest multiple of the wavelength, ties to even, then fold into a quarter turn
    always_comb begin
        w_adj    = r_pd[50] && (r_m != 24'd0);
        w_m2     = w_adj ? r_wl - r_m : r_m;
        w_odd    = w_adj ? ~r_q0 : r_q0;
        w_two_m  = {w_m2, 1'b0};
        if (w_two_m < {1'b0, r_wl}) begin
            w_r = $signed({2'b00, w_m2});
        end else if (w_two_m > {1'b0, r_wl} || w_odd) begin
            w_r = $signed({2'b00, w_m2}) - $signed({2'b00, r_wl});
        end else begin
            w_r = $signed({2'b00, w_m2});
        end
        w_n4     = {w_r, 2'b00};
        w_wl28   = $signed({4'b0000, r_wl});
        w_two_wl = $signed({3'b000, r_wl, 1'b0});
        w_fold   = 1'b1;
        if (w_n4 > w_wl28) begin
            w_n = w_n4 - w_two_wl;
        end else if (w_n4 < -w_wl28) begin
            w_n = w_n4 + w_two_wl;
        end else begin
            w_n    = w_n4;
            w_fold = 1'b0;
        end
        w_nabs = w_n[27] ? 28'(-w_n) : 28'(w_n);
    end

    always_comb begin
        w_shift   = su_res >> INTENSITY_SHIFT;
        w_int_ovf = |w_shift[127:64];
        w_int     = w_int_ovf ? '1 : w_shift[63:0];
        w_tsum    = {1'b0, r_total} + {1'b0, w_int};
        w_tot_ovf = w_tsum[64];
    end

    assign mem_wdata.ox    = i_s_tdata[47:0];
    assign mem_wdata.oy    = i_s_tdata[95:48];
    assign mem_wdata.oz    = i_s_tdata[143:96];
    assign mem_wdata.path  = i_s_tdata[191:144];
    assign mem_wdata.power = i_s_tdata[223:192];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    if (i_s_tuser == CMD_EVAL && r_count != '0) n_state = S_PWR_RD;
                    else                                        n_state = S_OUT;
                end
            end
            S_PWR_RD:  n_state = S_PWR_CHK;
            S_PWR_CHK: n_state = w_pwr_zero ? S_OUT : (w_last ? S_ORG_RD : S_PWR_RD);
            S_ORG_RD:  n_state = S_ORG_CHK;
            S_ORG_CHK: n_state = w_org_hit ? S_OUT : (w_last ? S_SMP_RD : S_ORG_RD);
            S_SMP_RD:  n_state = S_SQX_GO;
            S_SQX_GO:  n_state = S_SQX_WT;
            S_SQX_WT:  if (su_stat.done) n_state = S_SQY_GO;
            S_SQY_GO:  n_state = S_SQY_WT;
            S_SQY_WT:  if (su_stat.done) n_state = S_SQZ_GO;
            S_SQZ_GO:  n_state = S_SQZ_WT;
            S_SQZ_WT:  if (su_stat.done) n_state = S_DST_GO;
            S_DST_GO:  n_state = S_DST_WT;
            S_DST_WT:  if (su_stat.done) n_state = S_PWS_GO;
            S_PWS_GO:  n_state = S_PWS_WT;
            S_PWS_WT:  if (su_stat.done) n_state = S_AMP_GO;
            S_AMP_GO:  n_state = S_AMP_WT;
            S_AMP_WT:  if (su_stat.done) n_state = S_X0_GO;
            S_X0_GO:   n_state = S_X0_WT;
            S_X0_WT: begin
                if (su_stat.done) n_state = (r_wl == 24'd0) ? S_ROT_GO : S_PH_GO;
            end
            S_PH_GO:   n_state = S_PH_WT;
            S_PH_WT:   if (su_stat.done) n_state = S_FOLD;
            S_FOLD:    n_state = S_ANM_GO;
            S_ANM_GO:  n_state = S_ANM_WT;
            S_ANM_WT:  if (su_stat.done) n_state = S_AND_GO;
            S_AND_GO:  n_state = S_AND_WT;
            S_AND_WT:  if (su_stat.done) n_state = S_ROT_GO;
            S_ROT_GO:  n_state = S_ROT_WT;
            S_ROT_WT:  if (cor_done) n_state = w_last ? S_FX_GO : S_SMP_RD;
            S_FX_GO:   n_state = S_FX_WT;
            S_FX_WT:   if (su_stat.done) n_state = S_FY_GO;
            S_FY_GO:   n_state = S_FY_WT;
            S_FY_WT:   if (su_stat.done) n_state = S_FIN;
            S_FIN:     n_state = S_OUT;
            S_OUT:     if (!r_m_valid || i_m_tready) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // sequencer outputs: unit requests, table access
    always_comb begin
        su_req.start = 1'b0;
        su_req.op    = OP_MUL;
        su_a         = '0;
        su_b         = '0;
        su_c         = '0;
        mem_wen      = 1'b0;
        mem_ren      = 1'b0;
        cor_start    = 1'b0;
        unique case (r_state)
            S_IDLE:   mem_wen = s_acc && (i_s_tuser == CMD_LOAD) && !w_full;
            S_PWR_RD, S_ORG_RD, S_SMP_RD: mem_ren = 1'b1;
            S_SQX_GO: begin
                su_req.start = 1'b1;
                su_a = 128'(w_ux);
                su_b = 64'(w_ux);
            end
            S_SQY_GO: begin
                su_req.start = 1'b1;
                su_a = 128'(w_uy);
                su_b = 64'(w_uy);
                su_c = su_res;
            end
            S_SQZ_GO: begin
                su_req.start = 1'b1;
                su_a = 128'(w_uz);
                su_b = 64'(w_uz);
                su_c = su_res;
            end
            S_DST_GO: begin
                su_req = '{start: 1'b1, op: OP_SQRT};
                su_a   = su_res;
            end
            S_PWS_GO: begin
                su_req = '{start: 1'b1, op: OP_SQRT};
                su_a   = 128'({mem_rd.power, 32'd0});
            end
            S_AMP_GO: begin
                su_req = '{start: 1'b1, op: OP_DIV};
                su_a   = 128'({r_s, 40'd0});
                su_b   = 64'(r_dist);
            end
            S_X0_GO: begin
                su_req.start = 1'b1;
                su_a = 128'(r_amp);
                su_b = INV_GAIN_Q32;
            end
            S_PH_GO: begin
                su_req = '{start: 1'b1, op: OP_DIV};
                su_a   = 128'(w_pd_abs);
                su_b   = 64'(r_wl);
            end
            S_ANM_GO: begin
                su_req.start = 1'b1;
                su_a = 128'(r_mag);
                su_b = PI_Q36;
                su_c = 128'(r_wl);
            end
            S_AND_GO: begin
                su_req = '{start: 1'b1, op: OP_DIV};
                su_a   = su_res;
                su_b   = 64'({r_wl, 1'b0});
            end
            S_ROT_GO: cor_start = 1'b1;
            S_FX_GO: begin
                su_req.start = 1'b1;
                su_a = 128'(w_fx_abs);
                su_b = w_fx_abs;
            end
            S_FY_GO: begin
                su_req.start = 1'b1;
                su_a = 128'(w_fy_abs);
                su_b = w_fy_abs;
                su_c = su_res;
            end
            default: ;
        endcase
    end

    // control register next values
    always_comb begin
        n_count   = r_count;
        n_idx     = r_idx;
        n_total   = r_total;
        n_m_valid = r_m_valid;
        if (i_m_tready) n_m_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (s_acc && i_s_tuser == CMD_CLEAR) begin
                    n_count = '0;
                    n_total = '0;
                end else if (mem_wen) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            S_PWR_CHK, S_ORG_CHK: n_idx = w_last ? '0 : w_idx_inc;
            S_ROT_WT:  if (cor_done) n_idx = w_idx_inc;
            S_FIN:     n_total = w_tot_ovf ? '1 : w_tsum[63:0];
            S_OUT:     if (!r_m_valid || i_m_tready) n_m_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_total   <= '0;
            r_m_valid <= 1'b0;
            r_wl      <= WL_RESET;
            r_ref     <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_total   <= n_total;
            r_m_valid <= n_m_valid;
            if (i_cfg_wen) begin
                unique case (i_cfg_addr)
                    CFG_WAVELENGTH: r_wl  <= i_cfg_wdata[23:0];
                    CFG_REF_PATH:   r_ref <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_px     <= i_s_tdata[47:0];
            r_py     <= i_s_tdata[95:48];
            r_pz     <= i_s_tdata[143:96];
            r_fx     <= '0;
            r_fy     <= '0;
            r_sat    <= 1'b0;
            r_inten  <= '0;
            r_status <= ST_OK;
            if (i_s_tuser == CMD_LOAD && w_full)                  r_status <= ST_FULL;
            if (i_s_tuser == CMD_EVAL && r_count == '0)           r_status <= ST_EMPTY;
        end
        if (r_state == S_PWR_CHK && w_pwr_zero) r_status <= ST_ZPOW;
        if (r_state == S_ORG_CHK && w_org_hit)  r_status <= ST_ORIGIN;
        if (r_state == S_DST_WT && su_stat.done) r_dist <= su_res[49:0];
        if (r_state == S_PWS_GO) begin
            r_pd <= {3'b000, mem_rd.path} + {1'b0, r_dist} - {3'b000, r_ref};
        end
        if (r_state == S_PWS_WT && su_stat.done) r_s <= su_res[31:0];
        if (r_state == S_AMP_WT && su_stat.done) begin
            r_amp <= w_amp_ovf ? AMP_MAX : su_res[47:0];
            if (w_amp_ovf) r_sat <= 1'b1;
        end
        if (r_state == S_X0_WT && su_stat.done) begin
            r_x0   <= su_res[79:32];
            r_z    <= '0;
            r_flip <= 1'b0;
        end
        if (r_state == S_PH_WT && su_stat.done) begin
            r_q0 <= su_res[0];
            r_m  <= su_rem[23:0];
        end
        if (r_state == S_FOLD) begin
            r_mag  <= w_nabs[23:0];
            r_neg  <= w_n[27];
            r_flip <= w_fold;
        end
        if (r_state == S_AND_WT && su_stat.done) r_z <= r_neg ? -w_angz : w_angz;
        if (r_state == S_ROT_WT && cor_done) begin
            r_fx <= r_flip ? r_fx - w_cx : r_fx + w_cx;
            r_fy <= r_flip ? r_fy - w_cy : r_fy + w_cy;
        end
        if (r_state == S_FIN) begin
            r_inten  <= w_int;
            r_status <= (r_sat || w_int_ovf || w_tot_ovf) ? ST_SAT : ST_OK;
        end
        if (r_state == S_OUT && (!r_m_valid || i_m_tready)) begin
            r_m_inten  <= r_inten;
            r_m_total  <= r_total;
            r_m_status <= r_status;
        end
    end

    cpfs_mem #(
        .DEPTH  (MAX_SAMPLES),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_wen   (mem_wen),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (mem_wdata),
        .i_ren   (mem_ren),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (mem_rd)
    );

    cpfs_serial u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (su_req),
        .i_a     (su_a),
        .i_b     (su_b),
        .i_c     (su_c),
        .o_stat  (su_stat),
        .o_res   (su_res),
        .o_rem   (su_rem)
    );

    cpfs_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_z     (r_z),
        .i_x0    (cor_x0),
        .o_done  (cor_done),
        .o_x     (cor_x),
        .o_y     (cor_y)
    );

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {r_m_total, r_m_inten};
    assign o_m_tuser  = r_m_status;

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SAMPLES))
        else $error("sample count beyond table depth");

    a_su_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        su_req.start |-> !su_stat.busy)
        else $error("shared unit started while busy");

    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !o_s_tready)
        else $error("second transfer taken while an item is in work");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == ST_EMPTY || o_m_tuser == ST_ORIGIN ||
                        o_m_tuser == ST_ZPOW || o_m_tuser == ST_FULL))
        |-> (o_m_tdata[63:0] == 64'd0))
        else $error("failed command returned a nonzero intensity");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && o_m_tvalid && !i_m_tready) |=> (r_state == S_OUT))
        else $error("pending result would overwrite an untaken one");
`endif

endmodule
